[rtl/salt_pkg.sv]
// ----------------------------------------------------------------------------
// salt_pkg
// Shared types and constants of the set-associative LRU tag tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package salt_pkg;

  localparam int unsigned WAYS   = 4;
  localparam int unsigned SETS   = 256;   // power of two: the set is the low index bits
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned OUT_WAY_W = 4;
  localparam int unsigned CFG_W  = 4;

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;

  // Access kinds
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STORE  = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;

  // Configuration register indexes
  localparam logic REG_OFFSET_BITS = 1'b0;
  localparam logic REG_INDEX_BITS  = 1'b1;

  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][AGE_W-1:0]  age;
    logic [WAYS-1:0][TAG_W-1:0]  tag;
  } row_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] set;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] set;
    row_t             row;
  } wr_req_t;

endpackage

`default_nettype wire

[rtl/salt_if.sv]
// ----------------------------------------------------------------------------
// salt_if
// Valid/ready channels of the tracker: traced accesses in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface salt_acc_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] address;

  modport source (output valid, output action, output address, input ready);
  modport sink   (input valid, input action, input address, output ready);
endinterface

interface salt_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  way;
  logic        evicted;
  logic [31:0] hit_total;
  logic [31:0] read_hit_total;
  logic [31:0] write_hit_total;
  logic [31:0] miss_total;
  logic [31:0] read_miss_total;
  logic [31:0] write_miss_total;

  modport source (output valid, output hit, output way, output evicted,
                  output hit_total, output read_hit_total, output write_hit_total,
                  output miss_total, output read_miss_total, output write_miss_total,
                  input ready);
  modport sink   (input valid, input hit, input way, input evicted,
                  input hit_total, input read_hit_total, input write_hit_total,
                  input miss_total, input read_miss_total, input write_miss_total,
                  output ready);
endinterface

`default_nettype wire

[rtl/set_assoc_cache_lru_tracker_core.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tracker_core
// Set-associative cache tag tracker with true LRU replacement and
// saturating hit/miss counters.
// ----------------------------------------------------------------------------
// Usage:
//   acc_i carries one traced access per transaction (action, address).
//   res_o returns one result per access: hit, way, evicted and the six
//   running counters as they stand after that access.
//   Accesses are handled one at a time: on accept the selected set's row
//   is read from the set memory into a register; in the compare state the
//   block compares tags, picks the way, writes the updated row back and
//   loads the result register. A new access is accepted only once this single
//   read-modify-write of the set memory is done. The write lands before the
//   next read, so no forwarding is needed.
//   A finished result waits in the output register; a new access is taken
//   meanwhile, and it holds in the compare stage until the result register
//   frees up.
//   Reset clears the counters, restores offset_bits=6 and index_bits=8 and
//   marks every set empty through per-set flags; there is no clearing pass.
//   The user writes configuration (cfg_we_i/cfg_idx_i/cfg_data_i) only while
//   the block is idle; the block does not enforce it. Stored lines are kept across a change.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_tracker_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [salt_pkg::CFG_W-1:0] cfg_data_i,
  salt_acc_if.sink                       acc_i,
  salt_res_if.source                     res_o
);
  import salt_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic             state_q, state_d;
  logic [CFG_W-1:0] offset_bits_q, index_bits_q;
  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] set_q;
  logic             is_read_q;

  logic [CNT_W-1:0] hit_cnt_q, rd_hit_cnt_q, wr_hit_cnt_q;
  logic [CNT_W-1:0] miss_cnt_q, rd_miss_cnt_q, wr_miss_cnt_q;

  logic                 res_valid_q;
  logic                 res_hit_q;
  logic [OUT_WAY_W-1:0] res_way_q;
  logic                 res_evicted_q;

  logic             acc_fire;
  logic             advance;
  logic [ADDR_W-1:0] idx_full;
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;

  rd_req_t rd_req;
  wr_req_t wr_req;
  row_t    row;
  row_t    new_row;

  logic             hit;
  logic             found_free;
  logic [WAY_W-1:0] hit_way, free_way, vic_way, sel_way;

  // ---------------------------------------------------------------- input side
  assign acc_i.ready = (state_q == S_IDLE);
  assign acc_fire    = acc_i.valid && acc_i.ready;

  always_comb begin
    idx_full = (acc_i.address >> offset_bits_q) &
               ((ADDR_W'(1) << index_bits_q) - ADDR_W'(1));
    in_tag   = acc_i.address >> ({1'b0, offset_bits_q} + {1'b0, index_bits_q});
    // Wrap the index onto the sets present
    in_set   = (SETS > 1) ? idx_full[SET_W-1:0] : '0;
  end

  assign rd_req.en  = acc_fire;
  assign rd_req.set = in_set;

  salt_set_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd_req),
    .wr_i   (wr_req),
    .row_o  (row)
  );

  // ------------------------------------------------------------ lookup / LRU
  always_comb begin
    logic [AGE_W-1:0] best;
    logic [AGE_W:0]   old_age;
    hit        = 1'b0;
    hit_way    = '0;
    found_free = 1'b0;
    free_way   = '0;
    vic_way    = '0;
    best       = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && row.valid[w] && (row.tag[w] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!found_free && !row.valid[w]) begin
        found_free = 1'b1;
        free_way   = WAY_W'(w);
      end
      // Lowest-numbered way with the greatest age
      if (row.age[w] > best) begin
        best    = row.age[w];
        vic_way = WAY_W'(w);
      end
    end
    sel_way = hit ? hit_way : (found_free ? free_way : vic_way);

    // Age every valid way younger than the touched one, reset touched to 0
    old_age = row.valid[sel_way] ? {1'b0, row.age[sel_way]} : (AGE_W + 1)'(WAYS);
    new_row = row;
    for (int v = 0; v < WAYS; v++) begin
      if ((WAY_W'(v) != sel_way) && row.valid[v] && ({1'b0, row.age[v]} < old_age)) begin
        new_row.age[v] = row.age[v] + AGE_W'(1);
      end
    end
    new_row.age[sel_way]   = '0;
    new_row.valid[sel_way] = 1'b1;
    new_row.tag[sel_way]   = tag_q;
  end

  assign advance    = (state_q == S_LOOK) && (!res_valid_q || res_o.ready);
  assign wr_req.en  = advance;
  assign wr_req.set = set_q;
  assign wr_req.row = new_row;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (acc_fire) state_d = S_LOOK;
      S_LOOK: if (advance)  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk_i) begin
    if (acc_fire) begin
      tag_q     <= in_tag;
      set_q     <= in_set;
      is_read_q <= (acc_i.action == ACT_LOAD);
    end
    if (advance) begin
      res_hit_q     <= hit;
      res_way_q     <= OUT_WAY_W'(sel_way);
      res_evicted_q <= !hit && !found_free;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      offset_bits_q <= CFG_W'(6);
      index_bits_q  <= CFG_W'(8);
      res_valid_q   <= 1'b0;
      hit_cnt_q     <= '0;
      rd_hit_cnt_q  <= '0;
      wr_hit_cnt_q  <= '0;
      miss_cnt_q    <= '0;
      rd_miss_cnt_q <= '0;
      wr_miss_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
          REG_INDEX_BITS:  index_bits_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        // Saturating counters; anything but a load counts as a write
        if (hit) begin
          if (hit_cnt_q != CNT_MAX) hit_cnt_q <= hit_cnt_q + CNT_W'(1);
          if (is_read_q) begin
            if (rd_hit_cnt_q != CNT_MAX) rd_hit_cnt_q <= rd_hit_cnt_q + CNT_W'(1);
          end else begin
            if (wr_hit_cnt_q != CNT_MAX) wr_hit_cnt_q <= wr_hit_cnt_q + CNT_W'(1);
          end
        end else begin
          if (miss_cnt_q != CNT_MAX) miss_cnt_q <= miss_cnt_q + CNT_W'(1);
          if (is_read_q) begin
            if (rd_miss_cnt_q != CNT_MAX) rd_miss_cnt_q <= rd_miss_cnt_q + CNT_W'(1);
          end else begin
            if (wr_miss_cnt_q != CNT_MAX) wr_miss_cnt_q <= wr_miss_cnt_q + CNT_W'(1);
          end
        end
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ output side
  // Counters change only when a new result is loaded, so they drive the
  // result fields directly.
  assign res_o.valid            = res_valid_q;
  assign res_o.hit              = res_hit_q;
  assign res_o.way              = res_way_q;
  assign res_o.evicted          = res_evicted_q;
  assign res_o.hit_total        = hit_cnt_q;
  assign res_o.read_hit_total   = rd_hit_cnt_q;
  assign res_o.write_hit_total  = wr_hit_cnt_q;
  assign res_o.miss_total       = miss_cnt_q;
  assign res_o.read_miss_total  = rd_miss_cnt_q;
  assign res_o.write_miss_total = wr_miss_cnt_q;

endmodule

`default_nettype wire

[rtl/salt_set_store.sv]
// ----------------------------------------------------------------------------
// salt_set_store
// Per-set row memory (tags, valid bits, ages) with a registered read port
// and per-row init flags, so an untouched row reads as empty.
// ----------------------------------------------------------------------------
`default_nettype none

module salt_set_store (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire salt_pkg::rd_req_t rd_i,
  input  wire salt_pkg::wr_req_t wr_i,
  output salt_pkg::row_t        row_o
);
  import salt_pkg::*;

  row_t            mem [SETS];
  row_t            rd_row_q;
  logic [SETS-1:0] row_ok_q;
  logic            ok_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.set] <= wr_i.row;
    end
    if (rd_i.en) begin
      rd_row_q <= mem[rd_i.set];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
      ok_q     <= 1'b0;
    end else begin
      if (wr_i.en) begin
        row_ok_q[wr_i.set] <= 1'b1;
      end
      if (rd_i.en) begin
        ok_q <= row_ok_q[rd_i.set];
      end
    end
  end

  // An unwritten row holds no valid line and all ages zero
  always_comb begin
    row_o = rd_row_q;
    if (!ok_q) begin
      row_o.valid = '0;
      row_o.age   = '0;
    end
  end

endmodule

`default_nettype wire
